// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files of the ellipse point generator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EPG_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("epg assertion failed");

// Next-cycle implication, disabled during reset.
`define EPG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("epg assertion failed");

`endif

// File: hdl/epg_pkg.sv
// Package of the ellipse point generator: shared types, constants and the
// dot ordering function. No dependencies.
`default_nettype none

package epg_pkg;

  // Width of the dot index within an octant step and the index of the final one.
  localparam int DOT_IDX_W = 3;
  localparam logic [DOT_IDX_W-1:0] LAST_DOT = 3'd7;

  // Status of the shared scaling unit.
  typedef struct packed {
    logic busy;
    logic done;
  } scl_stat_t;

  // Which offset pair a dot uses and which signs it applies.
  typedef struct packed {
    logic second;
    logic neg_h;
    logic neg_v;
  } dot_sel_t;

  // Order: (+,+) (+,-) (-,+) (-,-) for the first pair, then the second pair.
  function automatic dot_sel_t dot_sel(input logic [DOT_IDX_W-1:0] idx);
    dot_sel_t s;
    s.second = idx[2];
    s.neg_h  = idx[1];
    s.neg_v  = idx[0];
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/epg_scaler.sv
// Shared scaling unit: one multiply by the minor radius, then a restoring
// divide by the major radius, one quotient bit a cycle. Uses epg_pkg.
`default_nettype none

module epg_scaler #(
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [RADIUS_BITS-1:0] operand,
  input  wire logic [RADIUS_BITS-1:0] minor,
  input  wire logic [RADIUS_BITS-1:0] major,
  output logic      [RADIUS_BITS-1:0] quotient,
  output epg_pkg::scl_stat_t          stat
);
  import epg_pkg::*;

  localparam int R     = RADIUS_BITS;
  localparam int CNT_W = $clog2(RADIUS_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RADIUS_BITS - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [R-1:0]     rem_r;
  logic [R-1:0]     quo_r;

  logic [2*R-1:0]   prod;
  logic [R:0]       trial;
  logic [R:0]       diff;
  logic             fits;
  logic [R-1:0]     rem_nxt;

  // Product of operand and minor radius; operand <= major keeps the high half below major
  assign prod = {{R{1'b0}}, operand} * {{R{1'b0}}, minor};

  // One restoring divide step
  assign trial   = {rem_r, quo_r[R-1]};
  assign diff    = trial - {1'b0, major};
  assign fits    = trial >= {1'b0, major};
  assign rem_nxt = fits ? diff[R-1:0] : trial[R-1:0];

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= prod[2*R-1:R];
      quo_r <= prod[R-1:0];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[R-2:0], fits};
    end
  end

  // Zero major radius means both radii zero: scaled value is 0
  assign quotient  = (major == '0) ? '0 : quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// File: hdl/epg_emitter.sv
// Dot emitter: holds one step's offsets and sends its eight dots through
// a registered output stage. Uses epg_pkg.
`default_nettype none

module epg_emitter #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int COLOR_BITS  = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [RADIUS_BITS-1:0]        h1,
  input  wire logic [RADIUS_BITS-1:0]        v1,
  input  wire logic [RADIUS_BITS-1:0]        h2,
  input  wire logic [RADIUS_BITS-1:0]        v2,
  input  wire logic [COORD_BITS-1:0]         cx,
  input  wire logic [COORD_BITS-1:0]         cy,
  input  wire logic [COLOR_BITS-1:0]         color,
  input  wire logic                          final_step,
  output logic                               busy,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_BITS+1:0]       out_dot_x,
  output logic signed [COORD_BITS+1:0]       out_dot_y,
  output logic [COLOR_BITS-1:0]              out_dot_value,
  output logic                               out_step_last,
  output logic                               out_done_res
);
  import epg_pkg::*;

  localparam int OW = COORD_BITS + 2;
  localparam int SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  logic                   pend_r;
  logic [DOT_IDX_W-1:0]   idx_r;
  logic                   out_valid_r;
  logic [RADIUS_BITS-1:0] h1_r, v1_r, h2_r, v2_r;
  logic [COORD_BITS-1:0]  cx_r, cy_r;
  logic [COLOR_BITS-1:0]  color_r;
  logic                   final_r;
  logic signed [OW-1:0]   dot_x_r, dot_y_r;
  logic [COLOR_BITS-1:0]  value_r;
  logic                   step_last_r;
  logic                   done_r;

  logic                   out_free;
  dot_sel_t               sel;
  logic [RADIUS_BITS-1:0] h_off, v_off;
  logic signed [SW-1:0]   cx_e, cy_e, h_e, v_e, px, py;

  assign out_free = !out_valid_r || !out_stall;

  // Offsets and signs of the current dot
  assign sel   = dot_sel(idx_r);
  assign h_off = sel.second ? h2_r : h1_r;
  assign v_off = sel.second ? v2_r : v1_r;
  assign cx_e  = signed'({{(SW-COORD_BITS){1'b0}}, cx_r});
  assign cy_e  = signed'({{(SW-COORD_BITS){1'b0}}, cy_r});
  assign h_e   = signed'({{(SW-RADIUS_BITS){1'b0}}, h_off});
  assign v_e   = signed'({{(SW-RADIUS_BITS){1'b0}}, v_off});
  assign px    = sel.neg_h ? (cx_e - h_e) : (cx_e + h_e);
  assign py    = sel.neg_v ? (cy_e - v_e) : (cy_e + v_e);

  // Control: pending step, dot index, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        pend_r <= 1'b1;
        idx_r  <= '0;
      end else if (pend_r && out_free) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == LAST_DOT) pend_r <= 1'b0;
      end
      if (out_free) out_valid_r <= pend_r;
    end
  end

  // Step job and output payload
  always_ff @(posedge clk) begin
    if (load) begin
      h1_r    <= h1;
      v1_r    <= v1;
      h2_r    <= h2;
      v2_r    <= v2;
      cx_r    <= cx;
      cy_r    <= cy;
      color_r <= color;
      final_r <= final_step;
    end
    if (pend_r && out_free) begin
      dot_x_r     <= px[OW-1:0];
      dot_y_r     <= py[OW-1:0];
      value_r     <= color_r;
      step_last_r <= (idx_r == LAST_DOT);
      done_r      <= final_r;
    end
  end

  assign busy          = pend_r;
  assign out_valid     = out_valid_r;
  assign out_dot_x     = dot_x_r;
  assign out_dot_y     = dot_y_r;
  assign out_dot_value = value_r;
  assign out_step_last = step_last_r;
  assign out_done_res  = done_r;

endmodule

`default_nettype wire

// File: hdl/ellipse_point_generator_unit.sv
// Top level of the ellipse point generator: step sequencer and walk state.
// Instantiates epg_scaler and epg_emitter; uses epg_pkg.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid, in_stall, in_begin_req .. in_dot_color| item in
//   out     | out_valid, out_stall, out_dot_x .. out_done_res | 8 dots out
//
// A step item holds the input through the check state, the two
// multiply-and-divide passes (x, then y) on the shared scaler and the
// hand-off to the emitter. The eight dots leave one a cycle, unless the
// output stalls, while the next item is scaled; a step while idle
// passes the check state, holds the input and emits nothing.
// Output stalls delay only the hand-off once the emitter still holds a step.
// Synchronous reset returns to idle; there is no clearing pass.
`default_nettype none

module ellipse_point_generator_unit #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int COLOR_BITS  = 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_begin_req,
  input  wire logic [COORD_BITS-1:0]   in_center_x,
  input  wire logic [COORD_BITS-1:0]   in_center_y,
  input  wire logic [RADIUS_BITS-1:0]  in_radius_x,
  input  wire logic [RADIUS_BITS-1:0]  in_radius_y,
  input  wire logic [COLOR_BITS-1:0]   in_dot_color,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [COORD_BITS+1:0] out_dot_x,
  output logic signed [COORD_BITS+1:0] out_dot_y,
  output logic [COLOR_BITS-1:0]        out_dot_value,
  output logic                         out_step_last,
  output logic                         out_done_res
);
  import epg_pkg::*;

  localparam int R  = RADIUS_BITS;
  localparam int XW = RADIUS_BITS + 1;
  localparam int EW = RADIUS_BITS + 3;
  localparam logic signed [EW-1:0] ONE = EW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_DISPATCH
  } state_t;

  state_t                  state_r;
  logic                    active_r;
  logic                    wide_r;
  logic [COORD_BITS-1:0]   cx_r, cy_r;
  logic [R-1:0]            major_r, minor_r;
  logic [COLOR_BITS-1:0]   color_r;
  logic signed [XW-1:0]    wx_r;
  logic [XW-1:0]           wy_r;
  logic signed [EW-1:0]    err_r;
  logic [R-1:0]            sx_r, sy_r;

  logic                    in_take;
  logic                    scl_start;
  logic [R-1:0]            scl_operand;
  logic [R-1:0]            scl_quotient;
  scl_stat_t               scl_stat;
  logic                    emit_busy;
  logic                    emit_load;
  logic                    wide_in;

  logic signed [EW-1:0]    x_e, y_e, err1, nx, ny, ne;
  logic                    wrap, last_step;
  logic [R-1:0]            h1, v1, h2, v2;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign wide_in  = in_radius_x > in_radius_y;

  // Scaler launches: x when a step starts, y when x is done
  assign scl_start   = ((state_r == ST_CHECK) && active_r) ||
                       ((state_r == ST_SCALE_X) && scl_stat.done);
  assign scl_operand = (state_r == ST_SCALE_X) ? wy_r[R-1:0] : wx_r[R-1:0];

  // Midpoint walk update
  assign x_e  = EW'(wx_r);
  assign y_e  = signed'({{(EW-XW){1'b0}}, wy_r});
  assign err1 = err_r - ((y_e <<< 1) + ONE);
  assign ny   = y_e + ONE;
  assign wrap = (err1 <= 0);
  assign nx   = wrap ? (x_e - ONE) : x_e;
  assign ne   = wrap ? (err1 + (nx <<< 1)) : err1;
  assign last_step = (nx < ny);

  // Offset pairs for the emitter
  assign h1 = wide_r ? wx_r[R-1:0] : sx_r;
  assign v1 = wide_r ? sy_r        : wy_r[R-1:0];
  assign h2 = wide_r ? wy_r[R-1:0] : sy_r;
  assign v2 = wide_r ? sx_r        : wx_r[R-1:0];

  assign emit_load = (state_r == ST_DISPATCH) && !emit_busy;

  // Sequencer and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      active_r <= 1'b0;
      wide_r   <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      major_r  <= '0;
      minor_r  <= '0;
      color_r  <= '0;
      wx_r     <= '0;
      wy_r     <= '0;
      err_r    <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            state_r <= ST_CHECK;
            if (in_begin_req) begin
              active_r <= 1'b1;
              wide_r   <= wide_in;
              cx_r     <= in_center_x;
              cy_r     <= in_center_y;
              color_r  <= in_dot_color;
              major_r  <= wide_in ? in_radius_x : in_radius_y;
              minor_r  <= wide_in ? in_radius_y : in_radius_x;
              wx_r     <= signed'({1'b0, wide_in ? in_radius_x : in_radius_y});
              wy_r     <= '0;
              err_r    <= signed'({3'b000, wide_in ? in_radius_x : in_radius_y});
            end
          end
        end
        ST_CHECK: begin
          state_r <= active_r ? ST_SCALE_X : ST_IDLE;
        end
        ST_SCALE_X: begin
          if (scl_stat.done) begin
            sx_r    <= scl_quotient;
            state_r <= ST_SCALE_Y;
          end
        end
        ST_SCALE_Y: begin
          if (scl_stat.done) begin
            sy_r    <= scl_quotient;
            state_r <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          if (!emit_busy) begin
            wx_r     <= nx[XW-1:0];
            wy_r     <= ny[XW-1:0];
            err_r    <= ne;
            active_r <= !last_step;
            state_r  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  epg_scaler #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_scaler (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scl_start),
    .operand  (scl_operand),
    .minor    (minor_r),
    .major    (major_r),
    .quotient (scl_quotient),
    .stat     (scl_stat)
  );

  epg_emitter #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_emitter (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (emit_load),
    .h1            (h1),
    .v1            (v1),
    .h2            (h2),
    .v2            (v2),
    .cx            (cx_r),
    .cy            (cy_r),
    .color         (color_r),
    .final_step    (last_step),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dot_x     (out_dot_x),
    .out_dot_y     (out_dot_y),
    .out_dot_value (out_dot_value),
    .out_step_last (out_step_last),
    .out_done_res  (out_done_res)
  );

endmodule

`default_nettype wire

// File: hdl/epg_checker.sv
// Port-level checker for the ellipse point generator, bound to the top level.
// Uses assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module epg_checker #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int COLOR_BITS  = 24
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic [RADIUS_BITS-1:0]  in_radius_x,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [COORD_BITS+1:0] out_dot_x,
  input wire logic signed [COORD_BITS+1:0] out_dot_y,
  input wire logic [COLOR_BITS-1:0]   out_dot_value,
  input wire logic                    out_step_last
);

  // Output item is held while stalled
  `EPG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `EPG_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                   $stable(out_dot_x) && $stable(out_dot_y) && $stable(out_dot_value))

  // Each accepted item keeps the input busy in the cycle after it is taken
  `EPG_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)

  // Within a step the next dot follows the one taken at once
  `EPG_ASSERT_NEXT(a_dot_burst, out_valid && !out_stall && !out_step_last, out_valid)

  // The x radius of an accepted item must hold no unknown bits
  `EPG_ASSERT_NOW(a_radius_known, in_valid && !in_stall, !$isunknown(in_radius_x))

endmodule

bind ellipse_point_generator_unit epg_checker #(
  .COORD_BITS (COORD_BITS),
  .RADIUS_BITS(RADIUS_BITS),
  .COLOR_BITS (COLOR_BITS)
) u_epg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_radius_x  (in_radius_x),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_dot_x    (out_dot_x),
  .out_dot_y    (out_dot_y),
  .out_dot_value(out_dot_value),
  .out_step_last(out_step_last)
);

`default_nettype wire

// File: dv/ellipse_point_generator_unit_tb.sv
// Self-checking testbench of ellipse_point_generator_unit: a scoreboard class
// predicts the eight dots of every octant step and checks them in order.
// Depends on epg_pkg and the ellipse_point_generator_unit RTL.
`default_nettype none

typedef logic signed [13:0] dot_coord_t;

typedef struct packed {
  dot_coord_t  x;
  dot_coord_t  y;
  logic [23:0] value;
  logic        last;
  logic        done;
} dot_t;

// Predicts the walk and holds the dots still due from the block
class dot_scoreboard;
  dot_t        dots_due[$];
  int          fault_cnt;
  bit          walking;
  bit          vert_scaled;
  int          ctr_x;
  int          ctr_y;
  int unsigned big_r;
  int unsigned small_r;
  logic [23:0] color_q;
  int          pos_x;
  int          pos_y;
  int          err_acc;

  function new();
    fault_cnt   = 0;
    walking     = 1'b0;
    vert_scaled = 1'b0;
    ctr_x       = 0;
    ctr_y       = 0;
    big_r       = 0;
    small_r     = 0;
    color_q     = '0;
    pos_x       = 0;
    pos_y       = 0;
    err_acc     = 0;
  endfunction

  function int pending();
    return dots_due.size();
  endfunction

  // v * minor / major, truncating; zero major gives zero
  function int scaled(int v);
    if (big_r == 0 || v <= 0) return 0;
    return int'((unsigned'(v) * small_r) / big_r);
  endfunction

  // One accepted item: returns 1 when it produced a step
  function bit walk_step(logic begin_req, logic [11:0] cx, logic [11:0] cy,
                         logic [10:0] rx, logic [10:0] ry, logic [23:0] col);
    int   h1, v1, h2, v2, nx, ny, ne, hx, vy, px, py;
    bit   final_step;
    dot_t d;
    if (begin_req) begin
      ctr_x       = int'(cx);
      ctr_y       = int'(cy);
      color_q     = col;
      vert_scaled = (rx > ry);
      big_r       = 32'(vert_scaled ? rx : ry);
      small_r     = 32'(vert_scaled ? ry : rx);
      pos_x       = int'(big_r);
      pos_y       = 0;
      err_acc     = int'(big_r);
      walking     = 1'b1;
    end
    if (!walking) return 1'b0;

    // offsets taken from the position before the walk advances
    if (vert_scaled) begin
      h1 = pos_x; v1 = scaled(pos_y); h2 = pos_y; v2 = scaled(pos_x);
    end else begin
      h1 = scaled(pos_x); v1 = pos_y; h2 = scaled(pos_y); v2 = pos_x;
    end

    // midpoint walk: one row up, maybe one column in
    nx = pos_x;
    ny = pos_y;
    ne = err_acc - (2 * ny + 1);
    ny = ny + 1;
    if (ne <= 0) begin
      nx = nx - 1;
      ne = ne + 2 * nx;
    end
    final_step = (nx < ny);
    pos_x   = nx;
    pos_y   = ny;
    err_acc = ne;
    if (final_step) walking = 1'b0;

    // dot k: bit 2 picks the pair, bit 1 negates h, bit 0 negates v
    for (int k = 0; k < 8; k++) begin
      hx = k[2] ? h2 : h1;
      vy = k[2] ? v2 : v1;
      px = k[1] ? ctr_x - hx : ctr_x + hx;
      py = k[0] ? ctr_y - vy : ctr_y + vy;
      d.x     = px[13:0];
      d.y     = py[13:0];
      d.value = color_q;
      d.last  = (k[2:0] == epg_pkg::LAST_DOT);
      d.done  = final_step;
      dots_due.push_back(d);
    end
    return 1'b1;
  endfunction

  function void field_ok(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: dot %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fault_cnt++;
    end
  endfunction

  function void check_dot(dot_t got);
    dot_t want;
    if (dots_due.size() == 0) begin
      $display("%0t: unexpected dot, expected none, got x=%0d y=%0d", $time,
               got.x, got.y);
      fault_cnt++;
      return;
    end
    want = dots_due.pop_front();
    field_ok("x", want.x, got.x);
    field_ok("y", want.y, got.y);
    field_ok("value", want.value, got.value);
    field_ok("step_last", want.last, got.last);
    field_ok("done", want.done, got.done);
  endfunction
endclass

module ellipse_point_generator_unit_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_begin_req = 1'b0;
  logic [11:0] in_center_x = '0;
  logic [11:0] in_center_y = '0;
  logic [10:0] in_radius_x = '0;
  logic [10:0] in_radius_y = '0;
  logic [23:0] in_dot_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  dot_coord_t  out_dot_x;
  dot_coord_t  out_dot_y;
  logic [23:0] out_dot_value;
  logic        out_step_last;
  logic        out_done_res;

  dot_scoreboard sb = new();

  int live_items = 0;
  int stall_left = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  ellipse_point_generator_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_begin_req (in_begin_req),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius_x  (in_radius_x),
    .in_radius_y  (in_radius_y),
    .in_dot_color (in_dot_color),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_dot_x    (out_dot_x),
    .out_dot_y    (out_dot_y),
    .out_dot_value(out_dot_value),
    .out_step_last(out_step_last),
    .out_done_res (out_done_res)
  );

  always #6 clk = ~clk;

  // mostly no gap, sometimes a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: stall pattern changes at the falling edge
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (!rx_quiet) stall_left = pick_gap();
    end
  end

  // result side: take dots at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_dot({out_dot_x, out_dot_y, out_dot_value, out_step_last, out_done_res});
  end

  task automatic send_item(bit b, logic [11:0] cx, logic [11:0] cy,
                           logic [10:0] rx, logic [10:0] ry, logic [23:0] col);
    int gap;
    @(negedge clk);
    in_valid     = 1'b1;
    in_begin_req = b;
    in_center_x  = cx;
    in_center_y  = cy;
    in_radius_x  = rx;
    in_radius_y  = ry;
    in_dot_color = col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.walk_step(b, cx, cy, rx, ry, col)) live_items++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid     = 1'b0;
      in_begin_req = 1'($urandom_range(0, 1));
      in_dot_color = 24'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // advance one step; fields other than begin are noise
  task automatic send_step();
    send_item(1'b0, 12'($urandom), 12'($urandom), 11'($urandom), 11'($urandom),
              24'($urandom));
  endtask

  // load an ellipse and step it until done or until max_steps items
  task automatic run_ellipse(logic [11:0] cx, logic [11:0] cy, logic [10:0] rx,
                             logic [10:0] ry, logic [23:0] col, int max_steps);
    int n;
    send_item(1'b1, cx, cy, rx, ry, col);
    n = 1;
    while (sb.walking && n < max_steps) begin
      send_step();
      n++;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: step while idle, all fields high and low
    send_item(1'b0, 12'hfff, 12'hfff, 11'h7ff, 11'h7ff, 24'hffffff);
    send_item(1'b0, 12'h000, 12'h000, 11'h000, 11'h000, 24'h000000);
    // both radii zero: single step of eight center dots
    send_item(1'b1, 12'd100, 12'd200, 11'd0, 11'd0, 24'h000000);
    send_step();
    // full radius at the origin corner: dots go negative
    run_ellipse(12'h000, 12'h000, 11'h7ff, 11'h7ff, 24'hffffff, 3);
    // abandoned mid-walk by a new begin; wide with zero minor
    run_ellipse(12'hfff, 12'hfff, 11'h7ff, 11'h000, 24'h5a5a5a, 2);
    // tall with zero minor
    run_ellipse(12'hfff, 12'h000, 11'h000, 11'h7ff, 24'ha5a5a5, 2);
    // complete small walks: wide, tall, round, tiny
    run_ellipse(12'd50, 12'd60, 11'd5, 11'd3, 24'h123456, 1000);
    run_ellipse(12'd70, 12'd80, 11'd3, 11'd5, 24'h654321, 1000);
    run_ellipse(12'd10, 12'd20, 11'd1, 11'd0, 24'hfedcba, 1000);
    run_ellipse(12'd4000, 12'd4090, 11'd4, 11'd4, 24'h00ff00, 1000);
    send_step();
    // hold off until the block has emptied
    drain();

    // random: mostly complete small walks, some abandoned, some noise
    while (live_items < 90) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 70)
        run_ellipse(12'($urandom), 12'($urandom), 11'($urandom_range(0, 24)),
                    11'($urandom_range(0, 24)), 24'($urandom), 1000);
      else if (r < 82)
        run_ellipse(12'($urandom), 12'($urandom), 11'($urandom_range(0, 2047)),
                    11'($urandom_range(0, 2047)), 24'($urandom),
                    $urandom_range(1, 6));
      else if (r < 92)
        run_ellipse(12'($urandom), 12'($urandom), 11'($urandom_range(0, 60)),
                    11'($urandom_range(0, 60)), 24'($urandom),
                    $urandom_range(1, 10));
      else
        repeat ($urandom_range(1, 3)) send_step();
      if ($urandom_range(0, 3) == 0) drain();
    end

    // wait for the last dots, then let the pipeline settle
    drain();
    repeat (60) @(posedge clk);
    if (sb.fault_cnt == 0) begin
      $display("** ellipse_point_generator_unit: PASSED **");
    end else begin
      $display("** ellipse_point_generator_unit: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("** ellipse_point_generator_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
